// ===== design/sfpa_pkg.sv =====
// Shared constants, codes, state type and divider result struct for the projector.
package sfpa_pkg;
  localparam int ANGLES   = 16;
  localparam int DET_COLS = 64;
  localparam int T_CELLS  = 16;
  localparam int SLICES   = 64;
  localparam int RESP_LEN = 16;

  localparam int ANG_W    = $clog2(ANGLES);
  localparam int COL_W    = $clog2(DET_COLS);
  localparam int T_W      = $clog2(T_CELLS);
  localparam int SLC_W    = $clog2(SLICES);
  localparam int K_W      = $clog2(RESP_LEN);
  localparam int ACC_AW   = ANG_W + COL_W + T_W;
  localparam int RESP_AW  = SLC_W + K_W;
  localparam int ACC_W    = 48;
  localparam int NUM_R_W  = 7;
  localparam int DIDX_W   = 10;
  localparam int CNT_W    = 5;
  localparam int SPAN_W   = T_W + CNT_W;
  localparam int DSTEP_W  = $clog2(DIDX_W);

  localparam logic [NUM_R_W-1:0] NUM_R_RESET = 7'd64;

  localparam logic [2:0] REQ_GAIN    = 3'd0;
  localparam logic [2:0] REQ_RESP    = 3'd1;
  localparam logic [2:0] REQ_SPAN    = 3'd2;
  localparam logic [2:0] REQ_PROJECT = 3'd3;
  localparam logic [2:0] REQ_READ    = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SKIP = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISP, S_DIV, S_GW, S_GWCAP,
    S_KADDR, S_KMUL1, S_KMUL2, S_KACC, S_RDWAIT, S_FIN
  } state_t;

  typedef struct packed {
    logic               done;
    logic [DIDX_W-1:0]  quot;
    logic [NUM_R_W-1:0] rem;
  } div_res_t;
endpackage

// ===== design/sparse_forward_projection_accumulate.sv =====
// Top level: sequencer, stores and saturating scatter-add of the sparse forward projector.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------------
//  in       | in_valid / in_stall       | req_type .. clear_after_read
//  out      | out_valid / out_stall     | read_data, updates, status
//  cfg      | cfg_write                 | cfg_data (num_r)
//
// A project item waits on the radix-2 divider, then walks each response weight in range
// through address, two passes through the shared multiplier and one accumulator
// read-modify-write; a skipped weight takes only the address step.
// One item at a time.
// After reset the accumulator is cleared one cell a cycle, with in_stall high.
// A stalled result holds in the output register while the next item is accepted.
module sparse_forward_projection_accumulate (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [6:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          req_type,
  input  logic [3:0]          angle_index,
  input  logic [5:0]          det_col,
  input  logic [5:0]          slice,
  input  logic [3:0]          position,
  input  logic [4:0]          span_count,
  input  logic [9:0]          detector_index,
  input  logic [15:0]         weight,
  input  logic signed [15:0]  voxel_value,
  input  logic                clear_after_read,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [47:0]  read_data,
  output logic [4:0]          updates,
  output logic [1:0]          status
);
  import sfpa_pkg::*;

  state_t state, state_next;

  logic [NUM_R_W-1:0] num_r;
  logic [2:0]         req_r;
  logic [ANG_W-1:0]   ang_r;
  logic [COL_W-1:0]   col_r;
  logic [SLC_W-1:0]   slc_r;
  logic [T_W-1:0]     pos_r;
  logic [CNT_W-1:0]   cnt_in_r;
  logic [DIDX_W-1:0]  didx_r;
  logic [15:0]        wt_r;
  logic [15:0]        vox_r;
  logic               clr_r;

  logic [15:0]        gain_table [ANGLES];
  logic [SLICES-1:0]  span_valid;
  logic [T_W-1:0]     span_start;
  logic [CNT_W-1:0]   span_cnt;
  logic [DIDX_W-1:0]  q_a;
  logic [NUM_R_W-1:0] q_c;
  logic [31:0]        gw;
  logic [CNT_W-1:0]   k;
  logic [CNT_W-1:0]   upd;
  logic               skipped;
  logic               sat;
  logic [ACC_W-1:0]   rd_val;
  logic [ACC_AW-1:0]  clr_addr;

  div_res_t           div_res;
  logic               div_start;
  logic [47:0]        mul_a;
  logic [15:0]        mul_b;
  logic [63:0]        mul_p;

  logic               span_we;
  logic [SPAN_W-1:0]  span_wdata;
  logic [SPAN_W-1:0]  span_rdata;
  logic               resp_we;
  logic [15:0]        resp_rdata;
  logic               acc_we;
  logic [ACC_AW-1:0]  acc_waddr;
  logic [ACC_AW-1:0]  acc_raddr;
  logic [ACC_W-1:0]   acc_wdata;
  logic [ACC_W-1:0]   acc_rdata;

  logic [CNT_W-1:0]   t_cell;
  logic               cell_oor;
  logic [ACC_AW-1:0]  proj_addr;
  logic [15:0]        vmag;
  logic [63:0]        p_round;
  logic [31:0]        mag;
  logic [ACC_W:0]     term;
  logic [ACC_W:0]     sum;
  logic [ACC_W-1:0]   sum_sat;
  logic               sum_ovf;
  logic               out_free;
  logic [CNT_W-1:0]   cnt_clip;

  assign t_cell    = {1'b0, span_start} + k;
  assign cell_oor  = (q_a >= DIDX_W'(ANGLES)) || (q_c >= NUM_R_W'(DET_COLS))
                     || (t_cell >= CNT_W'(T_CELLS));
  assign proj_addr = {q_a[ANG_W-1:0], q_c[COL_W-1:0], t_cell[T_W-1:0]};
  assign acc_raddr = (req_r == REQ_READ) ? {ang_r, col_r, pos_r} : proj_addr;
  assign vmag      = vox_r[15] ? 16'(-vox_r) : vox_r;
  assign p_round   = mul_p + 64'h8000_0000;
  assign mag       = p_round[63:32];
  assign term      = vox_r[15] ? -{17'd0, mag} : {17'd0, mag};
  assign sum       = {acc_rdata[ACC_W-1], acc_rdata} + term;
  assign sum_ovf   = sum[ACC_W] != sum[ACC_W-1];
  assign sum_sat   = sum_ovf ? {sum[ACC_W], {(ACC_W-1){~sum[ACC_W]}}} : sum[ACC_W-1:0];
  assign out_free  = !out_valid || !out_stall;
  assign cnt_clip  = (cnt_in_r > CNT_W'(RESP_LEN)) ? CNT_W'(RESP_LEN) : cnt_in_r;

  sfpa_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(didx_r), .divisor(num_r), .res(div_res)
  );

  sfpa_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  sfpa_ram #(.AW(SLC_W), .DW(SPAN_W)) u_span (
    .clk(clk), .we(span_we), .waddr(slc_r), .wdata(span_wdata),
    .raddr(slc_r), .rdata(span_rdata)
  );

  sfpa_ram #(.AW(RESP_AW), .DW(16)) u_resp (
    .clk(clk), .we(resp_we), .waddr({slc_r, pos_r}), .wdata(wt_r),
    .raddr({slc_r, k[K_W-1:0]}), .rdata(resp_rdata)
  );

  sfpa_ram #(.AW(ACC_AW), .DW(ACC_W)) u_acc (
    .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
    .raddr(acc_raddr), .rdata(acc_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (&clr_addr) state_next = S_IDLE;
      S_IDLE:   if (in_valid) state_next = S_DISP;
      S_DISP: begin
        case (req_r)
          REQ_PROJECT: state_next = (num_r == '0) ? S_FIN : S_DIV;
          REQ_READ:    state_next = S_RDWAIT;
          default:     state_next = S_FIN;
        endcase
      end
      S_DIV:    if (div_res.done) state_next = S_GW;
      S_GW:     state_next = S_GWCAP;
      S_GWCAP:  state_next = S_KADDR;
      S_KADDR: begin
        if (k == span_cnt) begin
          state_next = S_FIN;
        end else if (!cell_oor) begin
          state_next = S_KMUL1;
        end
      end
      S_KMUL1:  state_next = S_KMUL2;
      S_KMUL2:  state_next = S_KACC;
      S_KACC:   state_next = S_KADDR;
      S_RDWAIT: state_next = S_FIN;
      S_FIN:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = state != S_IDLE;
    div_start  = (state == S_DISP) && (req_r == REQ_PROJECT) && (num_r != '0);
    span_we    = (state == S_DISP) && (req_r == REQ_SPAN);
    span_wdata = {pos_r, cnt_clip};
    resp_we    = (state == S_DISP) && (req_r == REQ_RESP);
    mul_a      = '0;
    mul_b      = '0;
    acc_we     = 1'b0;
    acc_waddr  = acc_raddr;
    acc_wdata  = '0;
    case (state)
      S_CLEAR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_addr;
      end
      S_GW: begin
        mul_a = {32'd0, gain_table[q_a[ANG_W-1:0]]};
        mul_b = wt_r;
      end
      S_KMUL1: begin
        mul_a = {16'd0, gw};
        mul_b = resp_rdata;
      end
      S_KMUL2: begin
        mul_a = mul_p[47:0];
        mul_b = vmag;
      end
      S_KACC: begin
        acc_we    = 1'b1;
        acc_wdata = sum_sat;
      end
      S_RDWAIT: acc_we = clr_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      num_r      <= NUM_R_RESET;
      span_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        num_r <= cfg_data;
      end
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (span_we) begin
        span_valid[slc_r] <= 1'b1;
      end
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_r    <= req_type;
      ang_r    <= angle_index;
      col_r    <= det_col;
      slc_r    <= slice;
      pos_r    <= position;
      cnt_in_r <= span_count;
      didx_r   <= detector_index;
      wt_r     <= weight;
      vox_r    <= voxel_value;
      clr_r    <= clear_after_read;
    end
    case (state)
      S_DISP: begin
        k       <= '0;
        upd     <= '0;
        sat     <= 1'b0;
        rd_val  <= '0;
        skipped <= (req_r == REQ_PROJECT) && (num_r == '0);
        if (req_r == REQ_GAIN) begin
          gain_table[ang_r] <= wt_r;
        end
      end
      S_DIV: begin
        q_a <= div_res.quot;
        q_c <= div_res.rem;
      end
      S_GW: begin
        span_start <= span_valid[slc_r] ? span_rdata[SPAN_W-1:CNT_W] : '0;
        span_cnt   <= span_valid[slc_r] ? span_rdata[CNT_W-1:0] : '0;
      end
      S_GWCAP: gw <= mul_p[31:0];
      S_KADDR: begin
        if (k != span_cnt && cell_oor) begin
          skipped <= 1'b1;
          k       <= k + 1'b1;
        end
      end
      S_KACC: begin
        sat <= sat | sum_ovf;
        upd <= upd + 1'b1;
        k   <= k + 1'b1;
      end
      S_RDWAIT: rd_val <= acc_rdata;
      default: ;
    endcase
    if (state == S_FIN && out_free) begin
      read_data <= rd_val;
      updates   <= upd;
      status    <= sat ? ST_SAT : (skipped ? ST_SKIP : ST_OK);
    end
  end
endmodule

// ===== design/sfpa_div.sv =====
// Restoring divider, one quotient bit per cycle, splits the flat detector index.
module sfpa_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [sfpa_pkg::DIDX_W-1:0]  dividend,
  input  logic [sfpa_pkg::NUM_R_W-1:0] divisor,
  output sfpa_pkg::div_res_t           res
);
  import sfpa_pkg::*;

  logic               busy;
  logic               done;
  logic [DSTEP_W-1:0] step;
  logic [DIDX_W-1:0]  dq;
  logic [NUM_R_W-1:0] rem;
  logic [NUM_R_W-1:0] dsr;
  logic [NUM_R_W:0]   sh;
  logic [NUM_R_W:0]   diff;
  logic               fit;

  assign sh   = {rem, dq[DIDX_W-1]};
  assign diff = sh - {1'b0, dsr};
  assign fit  = sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        dq   <= dividend;
        rem  <= '0;
        dsr  <= divisor;
      end else if (busy) begin
        rem  <= fit ? diff[NUM_R_W-1:0] : sh[NUM_R_W-1:0];
        dq   <= {dq[DIDX_W-2:0], fit};
        step <= step + 1'b1;
        if (step == DSTEP_W'(DIDX_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.quot = dq;
  assign res.rem  = rem;
endmodule

// ===== design/sfpa_mul.sv =====
// Shared registered multiplier for gain, response and voxel products.
module sfpa_mul (
  input  logic        clk,
  input  logic [47:0] a,
  input  logic [15:0] b,
  output logic [63:0] p
);
  import sfpa_pkg::*;

  always_ff @(posedge clk) begin
    p <= {16'd0, a} * {48'd0, b};
  end
endmodule

// ===== design/sfpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sfpa_ram #(
  parameter int AW = 4,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/sfpa_chk.sv =====
// Port-level checker for the sparse forward projector, bound to the top level.
module sfpa_chk (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic signed [47:0]  read_data,
  input logic [4:0]          updates,
  input logic [1:0]          status
);
  import sfpa_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(status))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("undefined status code");

  a_proj_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && updates != '0 |-> read_data == '0)
    else $error("project result carries read data");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while previous item in work");
endmodule

bind sparse_forward_projection_accumulate sfpa_chk u_sfpa_chk (.*);

// ===== tb/sv/testbench.sv =====
// Testbench for the sparse forward projector: random and directed items checked against a predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sfpa_pkg::*;

  typedef struct {
    logic [2:0]         kind;
    logic [3:0]         angle;
    logic [5:0]         col;
    logic [5:0]         slc;
    logic [3:0]         pos;
    logic [4:0]         cnt;
    logic [9:0]         didx;
    logic [15:0]        wt;
    logic signed [15:0] vox;
    logic               clr;
  } request_t;

  typedef struct {
    logic [47:0] data;
    logic [4:0]  upd;
    logic [1:0]  st;
  } answer_t;

  class projection_scoreboard;
    logic [6:0]  num_r;
    logic [15:0] gain[ANGLES];
    logic [15:0] resp[SLICES*RESP_LEN];
    logic [3:0]  span_start[SLICES];
    logic [4:0]  span_cnt[SLICES];
    longint      acc_cell[ANGLES*DET_COLS*T_CELLS];
    answer_t     awaited[$];
    int          fails;

    function new();
      num_r = NUM_R_RESET;
      fails = 0;
      foreach (gain[i]) gain[i] = '0;
      foreach (resp[i]) resp[i] = '0;
      foreach (span_start[i]) begin
        span_start[i] = '0;
        span_cnt[i] = '0;
      end
      foreach (acc_cell[i]) acc_cell[i] = 0;
    endfunction

    function void note_request(request_t r);
      answer_t e;
      longint unsigned a, c, t, m, mag, vmag;
      longint term, sum;
      bit skipped, sat, neg;
      int addr;
      e = '{data: '0, upd: '0, st: ST_OK};
      case (r.kind)
        REQ_GAIN: gain[r.angle] = r.wt;
        REQ_RESP: resp[{r.slc, r.pos}] = r.wt;
        REQ_SPAN: begin
          span_start[r.slc] = r.pos;
          span_cnt[r.slc] = (r.cnt > RESP_LEN) ? 5'(RESP_LEN) : r.cnt;
        end
        REQ_PROJECT: begin
          skipped = 0;
          sat = 0;
          if (num_r == 0) begin
            skipped = 1;
          end else begin
            a = r.didx / num_r;
            c = r.didx % num_r;
            neg = r.vox[15];
            vmag = neg ? (64'h10000 - 64'(r.vox[15:0])) : 64'(r.vox[15:0]);
            for (int k = 0; k < span_cnt[r.slc]; k++) begin
              t = span_start[r.slc] + k;
              if (a >= ANGLES || c >= DET_COLS || t >= T_CELLS) begin
                skipped = 1;
              end else begin
                m = 64'(gain[a]) * 64'(r.wt) * 64'(resp[{r.slc, 4'(k)}]);
                mag = (m * vmag + 64'h80000000) >> 32;
                term = neg ? -longint'(mag) : longint'(mag);
                addr = (int'(a) * DET_COLS + int'(c)) * T_CELLS + int'(t);
                sum = acc_cell[addr] + term;
                if (sum > 64'sh7FFFFFFFFFFF) begin
                  sum = 64'sh7FFFFFFFFFFF;
                  sat = 1;
                end else if (sum < -64'sh800000000000) begin
                  sum = -64'sh800000000000;
                  sat = 1;
                end
                acc_cell[addr] = sum;
                e.upd++;
              end
            end
          end
          e.st = sat ? ST_SAT : (skipped ? ST_SKIP : ST_OK);
        end
        REQ_READ: begin
          addr = {r.angle, r.col, r.pos};
          e.data = acc_cell[addr][47:0];
          if (r.clr) acc_cell[addr] = 0;
        end
        default: ;
      endcase
      awaited.push_back(e);
    endfunction

    function void check_result(logic [47:0] data, logic [4:0] upd, logic [1:0] st);
      answer_t e;
      if (awaited.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result data=%h upd=%0d st=%0d", data, upd, st);
        return;
      end
      e = awaited.pop_front();
      if (data !== e.data || upd !== e.upd || st !== e.st) begin
        fails++;
        if (fails <= 10)
          $display("mismatch: expected data=%h upd=%0d st=%0d, got data=%h upd=%0d st=%0d",
                   e.data, e.upd, e.st, data, upd, st);
      end
    endfunction
  endclass

  logic clk, rst, cfg_write, in_valid, in_stall, out_valid, out_stall, clear_after_read;
  logic [6:0]  cfg_data;
  logic [2:0]  req_type;
  logic [3:0]  angle_index, position;
  logic [5:0]  det_col, slice;
  logic [4:0]  span_count, updates;
  logic [9:0]  detector_index;
  logic [15:0] weight;
  logic signed [15:0] voxel_value;
  logic signed [47:0] read_data;
  logic [1:0]  status;

  projection_scoreboard sb;
  int tx_idle_pct, rx_idle_pct, idle_cycles;
  bit gain_set[ANGLES];
  bit resp_set[SLICES*RESP_LEN];
  logic [3:0] last_a, last_t;
  logic [5:0] last_c;

  sparse_forward_projection_accumulate DUT (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(read_data, updates, status);
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 100000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send(request_t r);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    req_type <= r.kind;
    angle_index <= r.angle;
    det_col <= r.col;
    slice <= r.slc;
    position <= r.pos;
    span_count <= r.cnt;
    detector_index <= r.didx;
    weight <= r.wt;
    voxel_value <= r.vox;
    clear_after_read <= r.clr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(r);
    if (r.kind == REQ_GAIN) gain_set[r.angle] = 1;
    if (r.kind == REQ_RESP) resp_set[{r.slc, r.pos}] = 1;
  endtask

  function automatic request_t noise();
    request_t r;
    r.kind = 3'($urandom);
    r.angle = 4'($urandom);
    r.col = 6'($urandom);
    r.slc = 6'($urandom);
    r.pos = 4'($urandom);
    r.cnt = 5'($urandom);
    r.didx = 10'($urandom);
    r.wt = 16'($urandom);
    r.vox = 16'($urandom);
    r.clr = 1'($urandom);
    return r;
  endfunction

  task automatic send_project(logic [5:0] slc, logic [9:0] didx, logic [15:0] wt,
                              logic signed [15:0] vox);
    request_t r;
    int a, c, t;
    if (sb.num_r != 0) begin
      a = didx / sb.num_r;
      c = didx % sb.num_r;
      for (int k = 0; k < sb.span_cnt[slc]; k++) begin
        t = sb.span_start[slc] + k;
        if (a < ANGLES && c < DET_COLS && t < T_CELLS) begin
          if (!gain_set[a]) begin
            r = noise();
            r.kind = REQ_GAIN;
            r.angle = 4'(a);
            send(r);
          end
          if (!resp_set[{slc, 4'(k)}]) begin
            r = noise();
            r.kind = REQ_RESP;
            r.slc = slc;
            r.pos = 4'(k);
            send(r);
          end
          last_a = 4'(a);
          last_c = 6'(c);
          last_t = 4'(t);
        end
      end
    end
    r = noise();
    r.kind = REQ_PROJECT;
    r.slc = slc;
    r.didx = didx;
    r.wt = wt;
    r.vox = vox;
    send(r);
  endtask

  task automatic send_read(logic [3:0] a, logic [5:0] c, logic [3:0] t, logic clr);
    request_t r;
    r = noise();
    r.kind = REQ_READ;
    r.angle = a;
    r.col = c;
    r.pos = t;
    r.clr = clr;
    send(r);
  endtask

  task automatic send_write(logic [2:0] kind, logic [3:0] a, logic [5:0] slc,
                            logic [3:0] pos, logic [4:0] cnt, logic [15:0] wt);
    request_t r;
    r = noise();
    r.kind = kind;
    r.angle = a;
    r.slc = slc;
    r.pos = pos;
    r.cnt = cnt;
    r.wt = wt;
    send(r);
  endtask

  task automatic random_items(int n);
    request_t r;
    int sel, span;
    logic [5:0] slc;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      slc = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(7));
      span = (sb.num_r == 0) ? 1024 : sb.num_r * ANGLES + 8;
      if (sel < 40) begin
        send_project(slc, ($urandom_range(7) == 0) ? 10'($urandom)
                                                   : 10'($urandom_range(span > 1023 ? 1023 : span)),
                     ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom),
                     ($urandom_range(9) == 0) ? 16'sh8000 : 16'($urandom));
      end else if (sel < 65) begin
        if ($urandom_range(1)) send_read(last_a, last_c, last_t, 1'($urandom));
        else send_read(4'($urandom), 6'($urandom), 4'($urandom), 1'($urandom));
      end else if (sel < 77) begin
        send_write(REQ_RESP, 0, slc, 4'($urandom), 0, 16'($urandom));
      end else if (sel < 87) begin
        send_write(REQ_SPAN, 0, slc, 4'($urandom), 5'($urandom), 0);
      end else if (sel < 95) begin
        send_write(REQ_GAIN, 4'($urandom), 0, 0, 0, 16'($urandom));
      end else begin
        r = noise();
        r.kind = 3'($urandom_range(7, 5));
        send(r);
      end
    end
  endtask

  task automatic write_num_r(logic [6:0] v);
    while (sb.awaited.size() != 0) @(posedge clk);
    cfg_write <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 0;
    sb.num_r = v;
  endtask

  initial begin
    request_t r;
    sb = new();
    rst = 1;
    cfg_write = 0;
    cfg_data = '0;
    in_valid = 0;
    out_stall = 0;
    {req_type, angle_index, det_col, slice, position, span_count} = '0;
    {detector_index, weight, voxel_value, clear_after_read} = '0;
    tx_idle_pct = 26;
    rx_idle_pct = 68;
    idle_cycles = 0;
    last_a = 0;
    last_c = 0;
    last_t = 0;
    repeat (2) @(posedge clk);
    rst <= 0;

    write_num_r(7'd64);
    send_write(REQ_GAIN, 4'd0, 0, 0, 0, 16'hFFFF);
    send_write(REQ_GAIN, 4'd15, 0, 0, 0, 16'h0001);
    send_write(REQ_RESP, 0, 6'd0, 4'd0, 0, 16'hFFFF);
    send_write(REQ_RESP, 0, 6'd0, 4'd1, 0, 16'h0000);
    send_write(REQ_RESP, 0, 6'd0, 4'd2, 0, 16'h8000);
    send_write(REQ_SPAN, 0, 6'd0, 4'd14, 5'd3, 0);
    send_write(REQ_SPAN, 0, 6'd63, 4'd0, 5'd31, 0);
    send_project(6'd0, 10'd0, 16'hFFFF, 16'sh7FFF);
    send_project(6'd63, 10'd1023, 16'hFFFF, -16'sd32768);
    send_project(6'd0, 10'd0, 16'h0001, -16'sd1);
    send_read(4'd0, 6'd0, 4'd14, 1'b1);
    send_read(4'd0, 6'd0, 4'd14, 1'b0);
    send_read(4'd15, 6'd63, 4'd0, 1'b0);
    send_read(4'd15, 6'd63, 4'd15, 1'b1);
    for (int k = 5; k < 8; k++) begin
      r = noise();
      r.kind = 3'(k);
      send(r);
    end
    in_valid <= 0;

    write_num_r(7'd1);
    random_items(250);
    in_valid <= 0;
    tx_idle_pct = 68;
    rx_idle_pct = 26;
    write_num_r(7'd127);
    random_items(250);
    in_valid <= 0;
    write_num_r(7'd0);
    random_items(50);
    in_valid <= 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_num_r(7'($urandom_range(63, 2)));
    random_items(350);
    in_valid <= 0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.fails == 0 && sb.awaited.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
